### sv/imd_pkg.sv
// ----------------------------------------------------------------------------
// imd_pkg: shared definitions for the ITCH 5.0 message decoder
// Status codes, type letters, per-type lengths and the decoded record.
// ----------------------------------------------------------------------------
package imd_pkg;

  // Default capture depth in bytes
  localparam int unsigned LONGEST_MESSAGE_DEF = 40;
  // Bytes the decoder looks at (longest supported type)
  localparam int unsigned SCAN_BYTES = 40;
  // Byte count saturates here
  localparam logic [5:0] COUNT_MAX = 6'd63;

  // Status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_EMPTY       = 3'd1;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd2;
  localparam logic [2:0] ST_LENGTH      = 3'd3;
  localparam logic [2:0] ST_INVALID     = 3'd4;

  // Message type letters
  localparam logic [7:0] MT_SYSTEM_EVENT   = 8'h53; // 'S'
  localparam logic [7:0] MT_STOCK_DIR      = 8'h52; // 'R'
  localparam logic [7:0] MT_TRADING_ACTION = 8'h48; // 'H'
  localparam logic [7:0] MT_ADD_ORDER      = 8'h41; // 'A'
  localparam logic [7:0] MT_ADD_ORDER_MPID = 8'h46; // 'F'
  localparam logic [7:0] MT_EXECUTED       = 8'h45; // 'E'
  localparam logic [7:0] MT_EXECUTED_PRICE = 8'h43; // 'C'
  localparam logic [7:0] MT_CANCEL         = 8'h58; // 'X'
  localparam logic [7:0] MT_DELETE         = 8'h44; // 'D'
  localparam logic [7:0] MT_REPLACE        = 8'h55; // 'U'

  // Exact lengths per type
  localparam logic [5:0] LEN_SYSTEM_EVENT   = 6'd12;
  localparam logic [5:0] LEN_STOCK_DIR      = 6'd39;
  localparam logic [5:0] LEN_TRADING_ACTION = 6'd25;
  localparam logic [5:0] LEN_ADD_ORDER      = 6'd36;
  localparam logic [5:0] LEN_ADD_ORDER_MPID = 6'd40;
  localparam logic [5:0] LEN_EXECUTED       = 6'd31;
  localparam logic [5:0] LEN_EXECUTED_PRICE = 6'd36;
  localparam logic [5:0] LEN_CANCEL         = 6'd23;
  localparam logic [5:0] LEN_DELETE         = 6'd19;
  localparam logic [5:0] LEN_REPLACE        = 6'd35;
  localparam logic [5:0] LEN_NONE           = 6'd0;

  // Code characters
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_O = 8'h4F;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_Q = 8'h51;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_Y = 8'h59;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  type_code;
    logic [15:0] stock_locate;
    logic [15:0] tracking_number;
    logic [47:0] timestamp;
    logic [63:0] first_reference;
    logic [63:0] second_reference;
    logic [31:0] share_count;
    logic [31:0] price_value;
    logic [63:0] stock_symbol;
    logic [7:0]  code_char;
  } record_t;

  function automatic logic [5:0] need_length(logic [7:0] t);
    logic [5:0] n;
    unique case (t)
      MT_SYSTEM_EVENT:   n = LEN_SYSTEM_EVENT;
      MT_STOCK_DIR:      n = LEN_STOCK_DIR;
      MT_TRADING_ACTION: n = LEN_TRADING_ACTION;
      MT_ADD_ORDER:      n = LEN_ADD_ORDER;
      MT_ADD_ORDER_MPID: n = LEN_ADD_ORDER_MPID;
      MT_EXECUTED:       n = LEN_EXECUTED;
      MT_EXECUTED_PRICE: n = LEN_EXECUTED_PRICE;
      MT_CANCEL:         n = LEN_CANCEL;
      MT_DELETE:         n = LEN_DELETE;
      MT_REPLACE:        n = LEN_REPLACE;
      default:           n = LEN_NONE;
    endcase
    return n;
  endfunction

  function automatic logic code_ok(logic [7:0] t, logic [7:0] c);
    logic ok;
    unique case (t)
      MT_SYSTEM_EVENT:
        ok = (c == CH_O) || (c == CH_S) || (c == CH_Q) || (c == CH_M) ||
             (c == CH_E) || (c == CH_C);
      MT_TRADING_ACTION:
        ok = (c == CH_H) || (c == CH_P) || (c == CH_Q) || (c == CH_T);
      MT_ADD_ORDER, MT_ADD_ORDER_MPID:
        ok = (c == CH_B) || (c == CH_S);
      MT_EXECUTED_PRICE:
        ok = (c == CH_Y) || (c == CH_N);
      default:
        ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

### sv/imd_in_if.sv
// ----------------------------------------------------------------------------
// imd_in_if: message byte channel
// One message byte per request, with last-byte and no-byte flags.
// ----------------------------------------------------------------------------
interface imd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       no_byte;

  modport source (output valid, output data_byte, output last_byte,
                  output no_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte,
                  input no_byte, output ready);
endinterface

### sv/imd_out_if.sv
// ----------------------------------------------------------------------------
// imd_out_if: decoded record channel
// One decoded ITCH record per request.
// ----------------------------------------------------------------------------
interface imd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  type_code;
  logic [15:0] stock_locate;
  logic [15:0] tracking_number;
  logic [47:0] timestamp;
  logic [63:0] first_reference;
  logic [63:0] second_reference;
  logic [31:0] share_count;
  logic [31:0] price_value;
  logic [63:0] stock_symbol;
  logic [7:0]  code_char;

  modport source (output valid, output status, output type_code,
                  output stock_locate, output tracking_number, output timestamp,
                  output first_reference, output second_reference,
                  output share_count, output price_value, output stock_symbol,
                  output code_char, input ready);
  modport sink   (input valid, input status, input type_code,
                  input stock_locate, input tracking_number, input timestamp,
                  input first_reference, input second_reference,
                  input share_count, input price_value, input stock_symbol,
                  input code_char, output ready);
endinterface

### sv/itch_message_decoder_unit.sv
// ----------------------------------------------------------------------------
// itch_message_decoder_unit: ITCH 5.0 message decoder
// Captures message bytes and emits one decoded record per message.
// ----------------------------------------------------------------------------
// Output: the record for a message is registered and becomes valid in the cycle
//   after its last byte request is accepted.
// Throughput: one byte request per cycle while the output register is empty
//   or being taken; every request stalls while a record waits untaken.
// Reset: rst_n (synchronous, active low) clears the byte count and the
//   output valid; the capture buffer is not reset.
// ----------------------------------------------------------------------------
module itch_message_decoder_unit #(
  parameter int unsigned LONGEST_MESSAGE = imd_pkg::LONGEST_MESSAGE_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  imd_in_if.sink        in_chan,
  imd_out_if.source     out_chan
);
  import imd_pkg::*;

  localparam int unsigned IDX_W = $clog2(LONGEST_MESSAGE);

  // Capture buffer, byte count and output register
  logic [7:0]  msg_r [LONGEST_MESSAGE];
  logic [5:0]  cnt_r;
  logic [5:0]  cnt_nxt;
  logic        out_valid_r;
  record_t     rec_r;
  record_t     rec_nxt;

  logic        in_acc;
  logic        has_byte;
  logic        store_en;
  logic [6:0]  len_sum;
  logic [5:0]  len;
  logic [7:0]  bv [SCAN_BYTES];
  logic [SCAN_BYTES*8-1:0] flat;
  logic [7:0]  t;
  logic [7:0]  code;
  logic [5:0]  need;

  // Take a new request whenever the output register is free or draining
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign has_byte      = in_acc && !in_chan.no_byte;
  // Bytes past the buffer depth are dropped
  assign store_en      = has_byte && ({1'b0, cnt_r} < 7'(LONGEST_MESSAGE));

  // Message length including this request's byte, saturating
  assign len_sum = {1'b0, cnt_r} + {6'd0, !in_chan.no_byte};
  assign len     = (len_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : len_sum[5:0];

  // View of the message with the incoming byte merged in at its slot
  always_comb begin
    for (int i = 0; i < SCAN_BYTES; i++) begin
      bv[i] = (!in_chan.no_byte && cnt_r == 6'(i)) ? in_chan.data_byte : msg_r[i];
      flat[8*(SCAN_BYTES-1-i) +: 8] = bv[i];
    end
  end

  // Big-endian field extraction from byte position pos
  function automatic logic [7:0] tk8(logic [SCAN_BYTES*8-1:0] f, int pos);
    return f[8*(SCAN_BYTES-pos)-1 -: 8];
  endfunction
  function automatic logic [15:0] tk16(logic [SCAN_BYTES*8-1:0] f, int pos);
    return f[8*(SCAN_BYTES-pos)-1 -: 16];
  endfunction
  function automatic logic [23:0] tk24(logic [SCAN_BYTES*8-1:0] f, int pos);
    return f[8*(SCAN_BYTES-pos)-1 -: 24];
  endfunction
  function automatic logic [31:0] tk32(logic [SCAN_BYTES*8-1:0] f, int pos);
    return f[8*(SCAN_BYTES-pos)-1 -: 32];
  endfunction
  function automatic logic [39:0] tk40(logic [SCAN_BYTES*8-1:0] f, int pos);
    return f[8*(SCAN_BYTES-pos)-1 -: 40];
  endfunction
  function automatic logic [47:0] tk48(logic [SCAN_BYTES*8-1:0] f, int pos);
    return f[8*(SCAN_BYTES-pos)-1 -: 48];
  endfunction
  function automatic logic [63:0] tk64(logic [SCAN_BYTES*8-1:0] f, int pos);
    return f[8*(SCAN_BYTES-pos)-1 -: 64];
  endfunction

  assign t    = bv[0];
  assign need = need_length(t);

  // Pick the code character the type carries
  always_comb begin
    priority if (t == MT_SYSTEM_EVENT) begin
      code = bv[11];
    end else if (t == MT_TRADING_ACTION || t == MT_ADD_ORDER ||
                 t == MT_ADD_ORDER_MPID) begin
      code = bv[19];
    end else if (t == MT_EXECUTED_PRICE) begin
      code = bv[31];
    end else begin
      code = 8'd0;
    end
  end

  // Decode: empty, unsupported, length, code checks in that order
  always_comb begin
    rec_nxt = '0;
    priority if (len == 6'd0) begin
      rec_nxt.status = ST_EMPTY;
    end else if (need == LEN_NONE) begin
      rec_nxt.type_code = t;
      rec_nxt.status    = ST_UNSUPPORTED;
    end else if (len != need) begin
      rec_nxt.type_code = t;
      rec_nxt.status    = ST_LENGTH;
    end else if (!code_ok(t, code)) begin
      rec_nxt.type_code = t;
      rec_nxt.status    = ST_INVALID;
    end else begin
      rec_nxt.status          = ST_OK;
      rec_nxt.type_code       = t;
      rec_nxt.stock_locate    = tk16(flat, 1);
      rec_nxt.tracking_number = tk16(flat, 3);
      rec_nxt.timestamp       = tk48(flat, 5);
      rec_nxt.code_char       = code;
      unique case (t)
        MT_STOCK_DIR: begin
          rec_nxt.stock_symbol     = tk64(flat, 11);
          rec_nxt.first_reference  = {tk16(flat, 19), tk48(flat, 25)};
          rec_nxt.second_reference = {32'd0, tk24(flat, 31), tk8(flat, 38)};
          rec_nxt.share_count      = tk32(flat, 21);
          rec_nxt.price_value      = tk32(flat, 34);
        end
        MT_TRADING_ACTION: begin
          rec_nxt.stock_symbol    = tk64(flat, 11);
          rec_nxt.first_reference = {24'd0, tk40(flat, 20)};
        end
        MT_ADD_ORDER, MT_ADD_ORDER_MPID: begin
          rec_nxt.first_reference = tk64(flat, 11);
          rec_nxt.share_count     = tk32(flat, 20);
          rec_nxt.stock_symbol    = tk64(flat, 24);
          rec_nxt.price_value     = tk32(flat, 32);
          // Attribution only on the MPID variant
          if (t == MT_ADD_ORDER_MPID) begin
            rec_nxt.second_reference = {32'd0, tk32(flat, 36)};
          end
        end
        MT_EXECUTED, MT_EXECUTED_PRICE: begin
          rec_nxt.first_reference  = tk64(flat, 11);
          rec_nxt.share_count      = tk32(flat, 19);
          rec_nxt.second_reference = tk64(flat, 23);
          if (t == MT_EXECUTED_PRICE) begin
            rec_nxt.price_value = tk32(flat, 32);
          end
        end
        MT_CANCEL: begin
          rec_nxt.first_reference = tk64(flat, 11);
          rec_nxt.share_count     = tk32(flat, 19);
        end
        MT_DELETE: begin
          rec_nxt.first_reference = tk64(flat, 11);
        end
        MT_REPLACE: begin
          rec_nxt.first_reference  = tk64(flat, 11);
          rec_nxt.second_reference = tk64(flat, 19);
          rec_nxt.share_count      = tk32(flat, 27);
          rec_nxt.price_value      = tk32(flat, 31);
        end
        default: begin
          // System event carries only the header and its code
        end
      endcase
    end
  end

  // Byte count: advance on each byte, hold at saturation, clear at last byte
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc) begin
      priority if (in_chan.last_byte) begin
        cnt_nxt = 6'd0;
      end else if (has_byte && cnt_r != COUNT_MAX) begin
        cnt_nxt = cnt_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 6'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Capture buffer: one slot written per byte
  always_ff @(posedge clk) begin
    if (store_en) begin
      msg_r[cnt_r[IDX_W-1:0]] <= in_chan.data_byte;
    end
  end

  // Output register: load on a last-byte request, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_chan.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_chan.last_byte) begin
      rec_r <= rec_nxt;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.status           = rec_r.status;
  assign out_chan.type_code        = rec_r.type_code;
  assign out_chan.stock_locate     = rec_r.stock_locate;
  assign out_chan.tracking_number  = rec_r.tracking_number;
  assign out_chan.timestamp        = rec_r.timestamp;
  assign out_chan.first_reference  = rec_r.first_reference;
  assign out_chan.second_reference = rec_r.second_reference;
  assign out_chan.share_count      = rec_r.share_count;
  assign out_chan.price_value      = rec_r.price_value;
  assign out_chan.stock_symbol     = rec_r.stock_symbol;
  assign out_chan.code_char        = rec_r.code_char;

endmodule
